/* sv/wavps_pkg.sv */
// shared types, constants and tables of the wav pcm stream parser
package wavps_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       restart;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [15:0] sample;
      logic               last_sample;
      logic [15:0]        channel_count;
      logic [31:0]        sample_rate;
      logic [31:0]        sample_count;
      logic [2:0]         error_code;
   } rsp_type;

   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_FORMAT = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam logic [2:0] ERR_HEADER   = 3'd0;
   localparam logic [2:0] ERR_FMT_TAG  = 3'd1;
   localparam logic [2:0] ERR_DEPTH    = 3'd2;
   localparam logic [2:0] ERR_SUBFMT   = 3'd3;
   localparam logic [2:0] ERR_VALID    = 3'd4;
   localparam logic [2:0] ERR_ORDER    = 3'd5;

   localparam logic [15:0] TAG_PCM  = 16'h0001;
   localparam logic [15:0] TAG_EXT  = 16'hFFFE;
   localparam logic [31:0] TAG_FMT  = 32'h20746D66;
   localparam logic [31:0] TAG_DATA = 32'h61746164;
   localparam logic [3:0]  HDR_LAST = 4'd11;
   localparam logic [31:0] RECIP3   = 32'hAAAAAAAB;

   typedef enum logic [17:0] {
      PH_HDR    = 18'h00001,
      PH_ID     = 18'h00002,
      PH_SIZE   = 18'h00004,
      PH_TAG    = 18'h00008,
      PH_CHAN   = 18'h00010,
      PH_RATE   = 18'h00020,
      PH_BRATE  = 18'h00040,
      PH_ALIGN  = 18'h00080,
      PH_BITS   = 18'h00100,
      PH_EXTSZ  = 18'h00200,
      PH_VALID  = 18'h00400,
      PH_MASK   = 18'h00800,
      PH_GUID   = 18'h01000,
      PH_SKIP   = 18'h02000,
      PH_DATA   = 18'h04000,
      PH_DONE   = 18'h08000,
      PH_DIVMUL = 18'h10000,
      PH_DIVOUT = 18'h20000
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic       work;
      logic       restart;
      logic       emit;
      logic [1:0] kind;
      logic [2:0] err_code;
   } cmd_type;

   typedef struct packed {
      logic hdr_bad;
      logic hdr_end;
      logic fld_end;
      logic size_zero;
      logic tag_fmt;
      logic tag_data;
      logic bps_zero;
      logic skip_end;
      logic data_emit;
      logic data_last;
      logic guid_bad;
      logic tag_bad;
      logic bits_bad;
      logic valid_bad;
      logic ext;
      logic left_one;
      logic cnt_zero;
      logic out_busy;
   } status_type;

   function automatic logic [7:0] hdr_byte(input logic [3:0] i);
      logic [7:0] r;
      unique case (i)
         4'd0:    r = 8'h52;
         4'd1:    r = 8'h49;
         4'd2:    r = 8'h46;
         4'd3:    r = 8'h46;
         4'd8:    r = 8'h57;
         4'd9:    r = 8'h41;
         4'd10:   r = 8'h56;
         4'd11:   r = 8'h45;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] guid_byte(input logic [3:0] i);
      logic [7:0] r;
      unique case (i)
         4'd0:    r = 8'h01;
         4'd6:    r = 8'h10;
         4'd8:    r = 8'h80;
         4'd11:   r = 8'hAA;
         4'd13:   r = 8'h38;
         4'd14:   r = 8'h9B;
         4'd15:   r = 8'h71;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [4:0] fld_width(input phase_type p);
      logic [4:0] r;
      unique case (p)
         PH_ID, PH_SIZE, PH_RATE, PH_BRATE, PH_MASK: r = 5'd4;
         PH_GUID:                                    r = 5'd16;
         default:                                    r = 5'd2;
      endcase
      return r;
   endfunction

endpackage

/* sv/wavps_dpath.sv */
// datapath of the wav parser: field assembly, counters, division, output register
module wavps_dpath (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           in_byte,
   input  wavps_pkg::cmd_type   cmd,
   output wavps_pkg::status_type st,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output wavps_pkg::rsp_type   rsp_data
);

   logic [4:0]  fbi_ff, fbi_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] left_ff, left_in;
   logic [15:0] fmt_tag_ff, fmt_tag_in;
   logic [15:0] chan_ff, chan_in;
   logic [31:0] rate_ff, rate_in;
   logic [5:0]  bits_ff, bits_in;
   logic [2:0]  bps_ff, bps_in;
   logic [31:0] samp_left_ff, samp_left_in;
   logic [31:0] sbytes_ff, sbytes_in;
   logic [1:0]  sidx_ff, sidx_in;
   logic [63:0] prod_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   wavps_pkg::rsp_type rsp_ff, rsp_in;

   logic [4:0]  f;
   logic [4:0]  f_inc;
   logic [3:0]  hi;
   logic [31:0] shifted;
   logic [31:0] new_acc;
   logic [31:0] new_tag;
   logic [31:0] fv;
   logic [31:0] sb;
   logic [31:0] samp_dec;
   logic [31:0] cnt;
   logic [15:0] smp;
   logic        is_guid_mask;

   always_comb begin
      f        = cmd.restart ? 5'd0 : fbi_ff;
      f_inc    = f + 5'd1;
      hi       = (f >= 5'd12) ? wavps_pkg::HDR_LAST : f[3:0];
      shifted  = {24'd0, in_byte} << {f[1:0], 3'b000};
      new_acc  = acc_ff | shifted;
      new_tag  = ((f == 5'd0) ? 32'd0 : tag_ff) | shifted;
      is_guid_mask = (cmd.phase == wavps_pkg::PH_GUID) || (cmd.phase == wavps_pkg::PH_MASK);
      fv       = is_guid_mask ? acc_ff : new_acc;
      sb       = ((sidx_ff == 2'd0) ? 32'd0 : sbytes_ff) |
                 ({24'd0, in_byte} << {sidx_ff, 3'b000});
      samp_dec = (samp_left_ff == 32'd0) ? 32'd0 : samp_left_ff - 32'd1;
      unique case (bps_ff)
         3'd1:    smp = {~sb[7], sb[6:0], 8'd0};
         3'd2:    smp = sb[15:0];
         3'd3:    smp = sb[23:8];
         default: smp = sb[31:16];
      endcase
      unique case (bps_ff)
         3'd2:    cnt = left_ff >> 1;
         3'd3:    cnt = {1'b0, prod_ff[63:33]};
         3'd4:    cnt = left_ff >> 2;
         default: cnt = left_ff;
      endcase

      st.hdr_bad   = ((hi < 4'd4) || (hi >= 4'd8)) && (in_byte != wavps_pkg::hdr_byte(hi));
      st.hdr_end   = (hi == wavps_pkg::HDR_LAST);
      st.fld_end   = (f_inc >= wavps_pkg::fld_width(cmd.phase));
      st.size_zero = (new_acc == 32'd0);
      st.tag_fmt   = (tag_ff == wavps_pkg::TAG_FMT);
      st.tag_data  = (tag_ff == wavps_pkg::TAG_DATA);
      st.bps_zero  = (bps_ff == 3'd0);
      st.skip_end  = (left_ff <= 32'd1);
      st.data_emit = (({1'b0, sidx_ff} + 3'd1) >= bps_ff);
      st.data_last = (samp_dec == 32'd0);
      st.guid_bad  = (in_byte != wavps_pkg::guid_byte(f[3:0]));
      st.tag_bad   = (fv[15:0] != wavps_pkg::TAG_PCM) && (fv[15:0] != wavps_pkg::TAG_EXT);
      st.bits_bad  = (fv[15:0] != 16'd8) && (fv[15:0] != 16'd16) &&
                     (fv[15:0] != 16'd24) && (fv[15:0] != 16'd32);
      st.valid_bad = (acc_ff[15:0] != {10'd0, bits_ff});
      st.ext       = (fmt_tag_ff == wavps_pkg::TAG_EXT);
      st.left_one  = (left_ff == 32'd1);
      st.cnt_zero  = (cnt == 32'd0);
      st.out_busy  = rsp_valid_ff && rsp_stall;
   end

   always_comb begin
      fbi_in       = fbi_ff;
      acc_in       = acc_ff;
      tag_in       = tag_ff;
      left_in      = left_ff;
      fmt_tag_in   = fmt_tag_ff;
      chan_in      = chan_ff;
      rate_in      = rate_ff;
      bits_in      = bits_ff;
      bps_in       = cmd.restart ? 3'd0 : bps_ff;
      samp_left_in = samp_left_ff;
      sbytes_in    = sbytes_ff;
      sidx_in      = sidx_ff;
      if (cmd.restart) begin
         fbi_in = 5'd0;
      end
      if (cmd.work) begin
         unique case (cmd.phase)
            wavps_pkg::PH_HDR: begin
               fbi_in = st.hdr_end ? 5'd0 : {1'b0, hi + 4'd1};
               if (st.hdr_end) begin
                  tag_in = 32'd0;
               end
            end
            wavps_pkg::PH_ID: begin
               tag_in = new_tag;
               fbi_in = st.fld_end ? 5'd0 : f_inc;
               if (st.fld_end) begin
                  acc_in = 32'd0;
               end
            end
            wavps_pkg::PH_SIZE: begin
               acc_in = new_acc;
               fbi_in = f_inc;
               if (st.fld_end) begin
                  fbi_in  = 5'd0;
                  left_in = new_acc;
                  acc_in  = 32'd0;
               end
            end
            wavps_pkg::PH_SKIP: begin
               if (left_ff != 32'd0) begin
                  left_in = left_ff - 32'd1;
               end
               if (st.skip_end) begin
                  fbi_in = 5'd0;
               end
            end
            wavps_pkg::PH_DATA: begin
               sbytes_in = st.data_emit ? 32'd0 : sb;
               sidx_in   = st.data_emit ? 2'd0 : sidx_ff + 2'd1;
               if (st.data_emit) begin
                  samp_left_in = samp_dec;
               end
            end
            wavps_pkg::PH_TAG, wavps_pkg::PH_CHAN, wavps_pkg::PH_RATE,
            wavps_pkg::PH_BRATE, wavps_pkg::PH_ALIGN, wavps_pkg::PH_BITS,
            wavps_pkg::PH_EXTSZ, wavps_pkg::PH_VALID, wavps_pkg::PH_MASK,
            wavps_pkg::PH_GUID: begin
               if (!is_guid_mask) begin
                  acc_in = new_acc;
               end
               left_in = left_ff - 32'd1;
               fbi_in  = f_inc;
               if (st.fld_end) begin
                  fbi_in = 5'd0;
                  if ((cmd.phase != wavps_pkg::PH_VALID) &&
                      (cmd.phase != wavps_pkg::PH_MASK)) begin
                     acc_in = 32'd0;
                  end
                  if (cmd.phase == wavps_pkg::PH_TAG) begin
                     fmt_tag_in = fv[15:0];
                  end
                  if (cmd.phase == wavps_pkg::PH_CHAN) begin
                     chan_in = fv[15:0];
                  end
                  if (cmd.phase == wavps_pkg::PH_RATE) begin
                     rate_in = fv;
                  end
                  if ((cmd.phase == wavps_pkg::PH_BITS) && !st.bits_bad) begin
                     bits_in = fv[5:0];
                     bps_in  = fv[5:3];
                  end
               end
            end
            default: begin
            end
         endcase
      end
      if ((cmd.phase == wavps_pkg::PH_DIVOUT) && cmd.emit) begin
         samp_left_in = cnt;
         sidx_in      = 2'd0;
         sbytes_in    = 32'd0;
      end
   end

   // result word, unused fields zero
   always_comb begin
      rsp_in = '0;
      rsp_in.kind = cmd.kind;
      unique case (cmd.kind)
         wavps_pkg::KIND_SAMPLE: begin
            rsp_in.sample      = smp;
            rsp_in.last_sample = st.data_last;
         end
         wavps_pkg::KIND_FORMAT: begin
            rsp_in.channel_count = chan_ff;
            rsp_in.sample_rate   = rate_ff;
            rsp_in.sample_count  = cnt;
         end
         default: begin
            rsp_in.error_code = cmd.err_code;
         end
      endcase
      rsp_valid_in = cmd.emit ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fbi_ff       <= 5'd0;
         bps_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fbi_ff       <= fbi_in;
         bps_ff       <= bps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      tag_ff       <= tag_in;
      left_ff      <= left_in;
      fmt_tag_ff   <= fmt_tag_in;
      chan_ff      <= chan_in;
      rate_ff      <= rate_in;
      bits_ff      <= bits_in;
      samp_left_ff <= samp_left_in;
      sbytes_ff    <= sbytes_in;
      sidx_ff      <= sidx_in;
      prod_ff      <= left_ff * wavps_pkg::RECIP3;
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !(rsp_valid_ff && rsp_stall))
      else $error("result loaded over a waiting word");
   a_bps_range: assert property (@(posedge clock) disable iff (reset)
      bps_ff <= 3'd4)
      else $error("bytes per sample out of range");
   a_sidx_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.phase == wavps_pkg::PH_DATA && bps_ff != 3'd0) |-> ({1'b0, sidx_ff} < bps_ff))
      else $error("sample byte index past sample width");
`endif

endmodule

/* sv/wavps_ctrl.sv */
// controller of the wav parser: parse phase sequencer and error hold
module wavps_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_restart,
   input  wavps_pkg::status_type  st,
   output wavps_pkg::cmd_type     cmd,
   output logic                   req_stall
);

   wavps_pkg::phase_type phase_ff, phase_in, eff_phase, fmt_next;
   logic hold_ff, hold_in;
   logic step, fresh, work, fail, fin;
   logic [2:0] err;

   always_comb begin
      unique case (eff_phase)
         wavps_pkg::PH_TAG:   fmt_next = wavps_pkg::PH_CHAN;
         wavps_pkg::PH_CHAN:  fmt_next = wavps_pkg::PH_RATE;
         wavps_pkg::PH_RATE:  fmt_next = wavps_pkg::PH_BRATE;
         wavps_pkg::PH_BRATE: fmt_next = wavps_pkg::PH_ALIGN;
         wavps_pkg::PH_ALIGN: fmt_next = wavps_pkg::PH_BITS;
         wavps_pkg::PH_BITS:  fmt_next = wavps_pkg::PH_EXTSZ;
         wavps_pkg::PH_EXTSZ: fmt_next = wavps_pkg::PH_VALID;
         wavps_pkg::PH_VALID: fmt_next = wavps_pkg::PH_MASK;
         default:             fmt_next = wavps_pkg::PH_GUID;
      endcase
   end

   always_comb begin
      req_stall = (phase_ff == wavps_pkg::PH_DIVMUL) ||
                  (phase_ff == wavps_pkg::PH_DIVOUT) || st.out_busy;
      step      = req_valid && !req_stall;
      fresh     = step && req_restart;
      eff_phase = fresh ? wavps_pkg::PH_HDR : phase_ff;
      hold_in   = fresh ? 1'b0 : hold_ff;
      work      = step && !hold_in;
      phase_in  = eff_phase;
      fail      = 1'b0;
      fin       = 1'b0;
      err       = wavps_pkg::ERR_HEADER;
      cmd.emit  = 1'b0;
      cmd.kind  = wavps_pkg::KIND_SAMPLE;

      unique case (eff_phase)
         wavps_pkg::PH_HDR: begin
            if (work) begin
               if (st.hdr_bad) begin
                  fail = 1'b1;
               end else if (st.hdr_end) begin
                  phase_in = wavps_pkg::PH_ID;
               end
            end
         end
         wavps_pkg::PH_ID: begin
            if (work && st.fld_end) begin
               phase_in = wavps_pkg::PH_SIZE;
            end
         end
         wavps_pkg::PH_SIZE: begin
            if (work && st.fld_end) begin
               if (st.tag_fmt) begin
                  fail     = st.size_zero;
                  err      = wavps_pkg::ERR_ORDER;
                  phase_in = wavps_pkg::PH_TAG;
               end else if (st.tag_data) begin
                  fail     = st.bps_zero;
                  err      = wavps_pkg::ERR_ORDER;
                  phase_in = wavps_pkg::PH_DIVMUL;
               end else begin
                  phase_in = st.size_zero ? wavps_pkg::PH_ID : wavps_pkg::PH_SKIP;
               end
            end
         end
         wavps_pkg::PH_SKIP: begin
            if (work && st.skip_end) begin
               phase_in = wavps_pkg::PH_ID;
            end
         end
         wavps_pkg::PH_DATA: begin
            if (work && st.data_emit) begin
               cmd.emit = 1'b1;
               if (st.data_last) begin
                  phase_in = wavps_pkg::PH_DONE;
               end
            end
         end
         wavps_pkg::PH_DONE: begin
         end
         wavps_pkg::PH_DIVMUL: begin
            phase_in = wavps_pkg::PH_DIVOUT;
         end
         wavps_pkg::PH_DIVOUT: begin
            if (!st.out_busy) begin
               cmd.emit = 1'b1;
               cmd.kind = wavps_pkg::KIND_FORMAT;
               phase_in = st.cnt_zero ? wavps_pkg::PH_DONE : wavps_pkg::PH_DATA;
            end
         end
         default: begin
            // fmt chunk fields
            if (work) begin
               if ((eff_phase == wavps_pkg::PH_GUID) && st.guid_bad) begin
                  fail = 1'b1;
                  err  = wavps_pkg::ERR_SUBFMT;
               end else if (st.fld_end) begin
                  if ((eff_phase == wavps_pkg::PH_TAG) && st.tag_bad) begin
                     fail = 1'b1;
                     err  = wavps_pkg::ERR_FMT_TAG;
                  end else if ((eff_phase == wavps_pkg::PH_BITS) && st.bits_bad) begin
                     fail = 1'b1;
                     err  = wavps_pkg::ERR_DEPTH;
                  end else if ((eff_phase == wavps_pkg::PH_GUID) && st.valid_bad) begin
                     fail = 1'b1;
                     err  = wavps_pkg::ERR_VALID;
                  end else begin
                     fin = ((eff_phase == wavps_pkg::PH_BITS) && !st.ext) ||
                           (eff_phase == wavps_pkg::PH_GUID);
                     if (fin) begin
                        phase_in = st.left_one ? wavps_pkg::PH_ID : wavps_pkg::PH_SKIP;
                     end else begin
                        phase_in = fmt_next;
                        fail     = st.left_one;
                        err      = wavps_pkg::ERR_ORDER;
                     end
                  end
               end else begin
                  fail = st.left_one;
                  err  = wavps_pkg::ERR_ORDER;
               end
            end
         end
      endcase

      if (fail) begin
         hold_in  = 1'b1;
         phase_in = eff_phase;
         cmd.emit = 1'b1;
         cmd.kind = wavps_pkg::KIND_ERROR;
      end
      cmd.phase    = eff_phase;
      cmd.work     = work;
      cmd.restart  = fresh;
      cmd.err_code = err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= wavps_pkg::PH_HDR;
         hold_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         hold_ff  <= hold_in;
      end
   end

`ifndef ASSERT_OFF
   a_div_seq: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == wavps_pkg::PH_DIVMUL) |=> (phase_ff == wavps_pkg::PH_DIVOUT))
      else $error("division step skipped");
   a_hold_quiet: assert property (@(posedge clock) disable iff (reset)
      (hold_ff && !fresh) |-> !cmd.emit)
      else $error("result given while error held");
   a_err_holds: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.kind == wavps_pkg::KIND_ERROR) |=> hold_ff)
      else $error("error not held");
`endif

endmodule

/* sv/wav_pcm_stream_parser.sv */
// wav pcm stream parser top level: controller plus datapath
// one input byte is taken per cycle while req_stall is low; a byte gives its result word (if any) in the next cycle
// the data chunk header adds a 32x32 reciprocal multiply (PH_DIVMUL), then the count word (PH_DIVOUT)
// throughput is one byte per cycle, held back in PH_DIVMUL and PH_DIVOUT at the data chunk header
// and by rsp_stall on a waiting word
// reset (synchronous, active high) returns to the riff header; req restart does the same per file
module wav_pcm_stream_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  wavps_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output wavps_pkg::rsp_type  rsp_data
);

   // command and status between sequencer and datapath
   wavps_pkg::cmd_type    cmd;
   wavps_pkg::status_type st;

   // phase sequencer, error hold and input flow control
   wavps_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_restart (req_data.restart),
      .st          (st),
      .cmd         (cmd),
      .req_stall   (req_stall)
   );

   // field assembly, chunk and sample counters, sample conversion, output word register
   wavps_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .in_byte   (req_data.in_byte),
      .cmd       (cmd),
      .st        (st),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
